// ===== rtl/core/lkvc_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lkvc_pkg;

    // Field widths fixed by the channel definition
    localparam int unsigned FIELD_BITS = 32;
    localparam int unsigned CAP_BITS   = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FETCH,
        ST_UPDATE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic start;   // capture the accepted item, clear scan results
        logic rd_en;   // key read issued this cycle
        logic upd;     // commit state update and load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_stall;   // result register full and not drained this cycle
    } t_status;

endpackage

// ===== rtl/core/lkvc_if.sv =====
// Valid/ready channel interfaces for request and result transfers.
// Depends on lkvc_pkg for the field widths.
`timescale 1ns / 1ps

interface lkvc_in_if
    import lkvc_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [FIELD_BITS-1:0] lookup_key;
    logic signed [FIELD_BITS-1:0] write_value;

    modport source (output valid, output opcode, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input opcode, input lookup_key, input write_value,
                    output ready);
endinterface

interface lkvc_out_if
    import lkvc_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [FIELD_BITS-1:0] read_value;
    logic                         evicted;

    modport source (output valid, output hit, output read_value, output evicted,
                    input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    output ready);
endinterface

// ===== rtl/core/lru_key_value_cache_top.sv =====
// Top level of the LRU key/value cache: controller plus datapath.
// Depends on lkvc_pkg, lkvc_if, lkvc_ctrl and lkvc_dp.
//
// Usage:
//   i_in  : request channel (opcode 0 = get, 1 = put, lookup_key, write_value).
//   o_out : result channel (hit, read_value, evicted), one result per request.
//   i_cfg_valid / o_cfg_ready / i_cfg_data : capacity register write; always
//           ready, write only while no request is in flight.
//   A request is taken in the idle state, then the sequencer reads one key per
//   cycle from the key memory over all ENTRIES slots, settles the match and
//   reads the value memory in the LAST and FETCH states, and commits the
//   update in the UPDATE state. The next request is taken the cycle after
//   commit, so a new request is accepted only once the previous one has
//   committed. Reset empties the cache and sets the capacity to 16. A finished
//   result waits in the output register; a stalled receiver holds the next
//   item in its commit step until that register drains.
`timescale 1ns / 1ps

module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lkvc_in_if.sink             i_in,
    lkvc_out_if.source          o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_BITS-1:0] i_cfg_data
);

    localparam int unsigned IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_cmd                cmd;
    t_status             status;
    logic [IDX_BITS-1:0] rd_addr;
    logic                in_ready;

    // Accept configuration at any time
    assign o_cfg_ready = 1'b1;

    lkvc_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr)
    );

    lkvc_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_in_ready  (in_ready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .o_status    (status)
    );

endmodule

// ===== rtl/core/lkvc_ctrl.sv =====
// Sequencer for the LRU cache: accepts a request, walks the entries,
// then commits the update. Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_ctrl
    import lkvc_pkg::*;
#(
    parameter int unsigned ENTRIES = 16,
    localparam int unsigned IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_status             i_status,
    output t_cmd                o_cmd,
    output logic [IDX_BITS-1:0] o_rd_addr
);

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

    t_state              r_state, n_state;
    logic [IDX_BITS-1:0] r_cnt, n_cnt;

    // State and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_rd_addr  = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_LAST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_LAST: begin
                n_state = ST_FETCH;
            end
            ST_FETCH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!i_status.out_stall) begin
                    o_cmd.upd = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_SCAN) && (r_cnt == '0))
        else $error("start did not enter the scan at entry zero");
    a_upd_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd |-> !i_status.out_stall)
        else $error("update committed into a full result register");
    a_upd_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd |=> o_in_ready)
        else $error("sequencer did not return to idle after update");

endmodule

// ===== rtl/core/lkvc_dp.sv =====
// Datapath for the LRU cache: key/value memories, valid bits, recency
// ranks, scan registers and the result register. Depends on lkvc_pkg, lkvc_if.
`timescale 1ns / 1ps

module lkvc_dp
    import lkvc_pkg::*;
#(
    parameter int unsigned ENTRIES    = 16,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32,
    localparam int unsigned IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lkvc_in_if.sink             i_in,
    lkvc_out_if.source          o_out,
    input  logic                i_in_ready,
    input  logic                i_cfg_valid,
    input  logic [CAP_BITS-1:0] i_cfg_data,
    input  t_cmd                i_cmd,
    input  logic [IDX_BITS-1:0] i_rd_addr,
    output t_status             o_status
);

    localparam int unsigned CNT_BITS = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    // Storage
    logic [KEY_BITS-1:0]   r_keys   [ENTRIES];
    logic [VALUE_BITS-1:0] r_values [ENTRIES];
    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [IDX_BITS-1:0]   r_rank   [ENTRIES];
    logic [IDX_BITS-1:0]   n_rank   [ENTRIES];
    logic [CNT_BITS-1:0]   r_live, n_live;
    logic [CAP_BITS-1:0]   r_cap;

    // Captured request and scan results
    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_wval;
    logic [KEY_BITS-1:0]   r_key_q;
    logic [VALUE_BITS-1:0] r_val_q;
    logic                  r_chk_en;
    logic [IDX_BITS-1:0]   r_chk_idx;
    logic                  r_found, r_has_old, r_has_free;
    logic [IDX_BITS-1:0]   r_found_idx, r_found_rank, r_old_idx, r_old_rank, r_free_idx;

    // Result register
    logic                  r_out_vld;
    logic                  r_out_hit;
    logic [FIELD_BITS-1:0] r_out_val;
    logic                  r_out_ev;

    logic [CMP_BITS-1:0]   eff_cap;
    logic                  do_evict, do_insert, do_touch;
    logic [IDX_BITS-1:0]   slot_idx;

    // Request ready comes from the sequencer
    assign i_in.ready = i_in_ready;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // Clamp capacity to one and to the built depth
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CMP_BITS'(1);
        end else if (CMP_BITS'(r_cap) > CMP_BITS'(ENTRIES)) begin
            eff_cap = CMP_BITS'(ENTRIES);
        end else begin
            eff_cap = CMP_BITS'(r_cap);
        end
    end

    // Registered memory reads: key at scan address, value at the hit entry
    always_ff @(posedge i_clk) begin
        r_key_q <= r_keys[i_rd_addr];
        r_val_q <= r_values[r_found_idx];
    end

    // Scan pipeline valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_en <= 1'b0;
        end else begin
            r_chk_en <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= i_rd_addr;
    end

    // Capture request, then accumulate match, oldest and first free entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_has_old  <= 1'b0;
            r_has_free <= 1'b0;
        end else if (i_cmd.start) begin
            r_found    <= 1'b0;
            r_has_old  <= 1'b0;
            r_has_free <= 1'b0;
        end else if (r_chk_en) begin
            if (r_valid[r_chk_idx] && r_key_q == r_key && !r_found) begin
                r_found <= 1'b1;
            end
            if (r_valid[r_chk_idx] && (!r_has_old || r_rank[r_chk_idx] > r_old_rank)) begin
                r_has_old <= 1'b1;
            end
            if (!r_valid[r_chk_idx] && !r_has_free) begin
                r_has_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op        <= i_in.opcode;
            r_key       <= KEY_BITS'(i_in.lookup_key);
            r_wval      <= VALUE_BITS'(i_in.write_value);
            r_found_idx <= '0;
        end else if (r_chk_en) begin
            if (r_valid[r_chk_idx] && r_key_q == r_key && !r_found) begin
                r_found_idx  <= r_chk_idx;
                r_found_rank <= r_rank[r_chk_idx];
            end
            if (r_valid[r_chk_idx] && (!r_has_old || r_rank[r_chk_idx] > r_old_rank)) begin
                r_old_idx  <= r_chk_idx;
                r_old_rank <= r_rank[r_chk_idx];
            end
            if (!r_valid[r_chk_idx] && !r_has_free) begin
                r_free_idx <= r_chk_idx;
            end
        end
    end

    // Decide the update
    always_comb begin
        do_touch  = r_found;
        do_evict  = (r_op == OP_PUT) && !r_found && r_has_old &&
                    (CMP_BITS'(r_live) >= eff_cap);
        do_insert = (r_op == OP_PUT) && !r_found && (r_has_free || do_evict);
        if (do_evict && (!r_has_free || r_old_idx < r_free_idx)) begin
            slot_idx = r_old_idx;
        end else begin
            slot_idx = r_free_idx;
        end
    end

    // Per-entry valid and rank update
    always_comb begin
        n_live = r_live;
        for (int i = 0; i < ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            n_rank[i]  = r_rank[i];
            if (do_touch) begin
                if (r_valid[i] && r_rank[i] < r_found_rank) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
                if (IDX_BITS'(i) == r_found_idx) begin
                    n_rank[i] = '0;
                end
            end else if (do_insert) begin
                if (do_evict && IDX_BITS'(i) == r_old_idx) begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end
                if (n_valid[i]) begin
                    n_rank[i] = n_rank[i] + 1'b1;
                end
                if (IDX_BITS'(i) == slot_idx) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end
            end
        end
        if (do_insert && !do_evict) begin
            n_live = r_live + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_live  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.upd) begin
            r_valid <= n_valid;
            r_live  <= n_live;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && do_insert) begin
            r_keys[slot_idx]   <= r_key;
            r_values[slot_idx] <= r_wval;
        end else if (i_cmd.upd && r_op == OP_PUT && r_found) begin
            r_values[r_found_idx] <= r_wval;
        end
    end

    // Result register: drop on transfer, load on update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.upd) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_out_hit <= r_found;
            r_out_ev  <= do_evict;
            if (r_op == OP_PUT) begin
                r_out_val <= '0;
            end else if (r_found) begin
                r_out_val <= FIELD_BITS'(r_val_q);
            end else begin
                r_out_val <= '1;
            end
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.hit          = r_out_hit;
    assign o_out.read_value   = r_out_val;
    assign o_out.evicted      = r_out_ev;
    assign o_status.out_stall = r_out_vld && !o_out.ready;

    // Checks
    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live == CNT_BITS'($countones(r_valid)))
        else $error("live count disagrees with valid bits");
    a_upd_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |=> r_out_vld)
        else $error("update did not load the result register");
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd && do_evict) |-> (r_live != '0))
        else $error("eviction with no live entry");

endmodule

// ===== dv/lkvc_checker.sv =====
// Checker for the LRU key/value cache: watches request, result and capacity transfers,
// keeps its own copy of the cache state and compares every result in order.
// Depends on lkvc_pkg and lkvc_if.
`timescale 1ns / 1ps

module lkvc_checker
    import lkvc_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lkvc_in_if.sink             i_req,
    lkvc_out_if.sink            i_res,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [CAP_BITS-1:0] i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_hits,
    output int                  o_evictions,
    output int                  o_results
);

    typedef struct packed {
        logic                    hit;
        logic [FIELD_BITS-1:0]   read_value;
        logic                    evicted;
    } t_lookup_result;

    logic [FIELD_BITS-1:0] cached_key   [DEPTH];
    logic [FIELD_BITS-1:0] cached_value [DEPTH];
    logic                  slot_live    [DEPTH];
    int unsigned           slot_age     [DEPTH];
    int unsigned           live_entries;
    logic [CAP_BITS-1:0]   capacity;
    t_lookup_result        expected_results[$];

    assign o_pending = expected_results.size();

    // move one slot to the front; younger live slots age by one
    function automatic void make_recent(int unsigned idx);
        int unsigned r;
        r = slot_age[idx];
        for (int i = 0; i < DEPTH; i++)
            if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
        slot_age[idx] = 0;
    endfunction

    // apply one request to the shadow cache and return its result
    function automatic t_lookup_result cache_access(logic op, logic [FIELD_BITS-1:0] key,
                                                    logic [FIELD_BITS-1:0] val);
        t_lookup_result res;
        int             found;
        int             victim;
        int             free_slot;
        int unsigned    cap;
        int unsigned    oldest;
        found = -1;
        res   = '0;
        for (int i = 0; i < DEPTH; i++)
            if (found < 0 && slot_live[i] && cached_key[i] == key) found = i;
        res.hit = (found >= 0);
        if (op == OP_GET) begin
            if (found >= 0) begin
                res.read_value = cached_value[found];
                make_recent(found);
            end else begin
                res.read_value = '1;
            end
        end else if (found >= 0) begin
            cached_value[found] = val;
            make_recent(found);
        end else begin
            cap = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : capacity);
            if (live_entries >= cap && live_entries > 0) begin
                victim = -1;
                oldest = 0;
                for (int i = 0; i < DEPTH; i++)
                    if (slot_live[i] && (victim < 0 || slot_age[i] > oldest)) begin
                        victim = i;
                        oldest = slot_age[i];
                    end
                if (victim >= 0) begin
                    slot_live[victim] = 1'b0;
                    slot_age[victim]  = 0;
                    live_entries--;
                    res.evicted = 1'b1;
                end
            end
            free_slot = -1;
            for (int i = 0; i < DEPTH; i++)
                if (free_slot < 0 && !slot_live[i]) free_slot = i;
            if (free_slot >= 0) begin
                for (int i = 0; i < DEPTH; i++)
                    if (slot_live[i]) slot_age[i]++;
                cached_key[free_slot]   = key;
                cached_value[free_slot] = val;
                slot_live[free_slot]    = 1'b1;
                slot_age[free_slot]     = 0;
                live_entries++;
            end
        end
        return res;
    endfunction

    // predict on request transfers, compare on result transfers
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                slot_live[i] = 1'b0;
                slot_age[i]  = 0;
            end
            live_entries = 0;
            capacity     = CAP_RESET;
            expected_results.delete();
            o_fail_count = 0;
            o_hits       = 0;
            o_evictions  = 0;
            o_results    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) capacity = i_cfg_data;
            if (i_req.valid && i_req.ready)
                expected_results.push_back(cache_access(i_req.opcode, i_req.lookup_key,
                                                        i_req.write_value));
            if (i_res.valid && i_res.ready) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: hit=%0b value=%h evicted=%0b",
                             $time, i_res.hit, i_res.read_value, i_res.evicted);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.hit) o_hits++;
                    if (want.evicted) o_evictions++;
                    if (want.hit !== i_res.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, i_res.hit);
                        o_fail_count++;
                    end
                    if (want.read_value !== i_res.read_value) begin
                        $display("%0t: read_value expected %h actual %h", $time,
                                 want.read_value, i_res.read_value);
                        o_fail_count++;
                    end
                    if (want.evicted !== i_res.evicted) begin
                        $display("%0t: evicted expected %0b actual %0b", $time,
                                 want.evicted, i_res.evicted);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/lru_key_value_cache_top_test.sv =====
// Testbench top for the LRU key/value cache: clock, reset, request and capacity
// stimulus with random gaps and stalls, and the verdict. Depends on lkvc_pkg,
// lkvc_if, lkvc_checker and the block itself.
`timescale 1ns / 1ps

module lru_key_value_cache_top_test;
    import lkvc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAP_BITS-1:0] cfg_data;
    int                  fail_count;
    int                  pending;
    int                  hit_count;
    int                  evict_count;
    int                  result_count;
    int                  idle_cycles;
    int                  items_sent;
    int                  stall_mode;
    logic [FIELD_BITS-1:0] key_pool[8];

    lkvc_in_if  req_ch ();
    lkvc_out_if res_ch ();

    lru_key_value_cache_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_ch.sink),
        .o_out      (res_ch.source),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    lkvc_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch.sink),
        .i_res       (res_ch.sink),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_hits      (hit_count),
        .o_evictions (evict_count),
        .o_results   (result_count)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // receiver stall pattern: phases of no stall, light and heavy stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b1;
            stall_mode   <= 0;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                default: res_ch.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("lru_key_value_cache_top_test: errors");
            $finish;
        end
    end

    // hold one request until it transfers; ignores idle gaps
    task automatic send_request(logic op, logic [FIELD_BITS-1:0] key,
                                logic [FIELD_BITS-1:0] val);
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.lookup_key  <= key;
        req_ch.write_value <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic idle_gap(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // wait for every result, then let the block settle before a capacity write
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (25) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [FIELD_BITS-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8) return key_pool[sel];
        return $urandom();
    endfunction

    // one random phase: bursts of mostly pooled keys with random gaps
    task automatic random_phase(int count);
        int burst;
        int done;
        done = 0;
        while (done < count) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && done < count; b++) begin
                send_request($urandom_range(0, 1), pick_key(), $urandom());
                done++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
        end
    endtask

    initial begin
        logic [CAP_BITS-1:0] caps[8];
        i_rst_n            = 1'b0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_GET;
        req_ch.lookup_key  = '0;
        req_ch.write_value = '0;
        items_sent         = 0;
        caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd8, 5'd2};
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: miss on empty, extremes, update, hit, fill past capacity
        send_request(OP_GET, 32'h8000_0000, 32'h0);
        send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_PUT, 32'h0, 32'h0);
        send_request(OP_GET, 32'h8000_0000, 32'h1234_5678);
        send_request(OP_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA);
        send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
        for (int i = 1; i <= 14; i++) send_request(OP_PUT, i * 32'h1111, i);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_GET, 32'h0, 32'h0);

        // lower capacity below the live count; inserts evict one each
        write_capacity(5'd3);
        send_request(OP_PUT, 32'hDEAD_BEEF, 32'hAAAA_5555);
        send_request(OP_PUT, 32'h1111, 32'h0);
        send_request(OP_GET, 32'hDEAD_BEEF, 32'h0);

        // random phases over several capacities, pool rebuilt per phase
        for (int p = 0; p < 8; p++) begin
            write_capacity(caps[p]);
            for (int k = 0; k < 8; k++) key_pool[k] = $urandom();
            random_phase(120);
        end
        write_capacity(5'd16);

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("sent %0d requests over 9 capacity settings (0, 1, 2, 3, 4, 8, 16, 17, 31)",
                 items_sent);
        $display("checked %0d results: %0d hits, %0d evictions", result_count, hit_count,
                 evict_count);
        if (fail_count == 0 && pending == 0)
            $display("lru_key_value_cache_top_test: clean");
        else
            $display("lru_key_value_cache_top_test: errors");
        $finish;
    end

endmodule
